/* sv/ltsc_pkg.sv */
// line track steer controller: shared widths, codes, reset values and types
// no dependencies; used by every other file of the block
`default_nettype none

package ltsc_pkg;

  localparam int TIME_W    = 32;
  localparam int ERR_W     = 16;
  localparam int DB_W      = 15;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int MAG_W     = 16;
  localparam int STEER_W   = 17;
  localparam int MOT_W     = 2;
  localparam int CMD_W     = 2;

  localparam logic [MOT_W-1:0] MOT_STOP  = 2'd0;
  localparam logic [MOT_W-1:0] MOT_FWD   = 2'd1;
  localparam logic [MOT_W-1:0] MOT_LEFT  = 2'd2;
  localparam logic [MOT_W-1:0] MOT_RIGHT = 2'd3;

  localparam logic [CMD_W-1:0] CMD_NONE     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PLATFORM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIT     = 3'd4;

  localparam logic [DB_W-1:0]  RST_DEADBAND = 15'd35;
  localparam logic [CFG_W-1:0] RST_GAIN     = 16'd5243;
  localparam logic [CFG_W-1:0] RST_MAX      = 16'd2048;
  localparam logic [CFG_W-1:0] RST_RECOVER  = 16'd500;
  localparam logic [CFG_W-1:0] RST_GAIT     = 16'd150;

  // steer decision handed from the steer unit to the control logic
  typedef struct packed {
    logic             turn_right;
    logic             turn_left;
    logic [MAG_W-1:0] mag;
  } steer_t;

endpackage

`default_nettype wire

/* sv/ltsc_if.sv */
// valid/ready channel interfaces for pass items and result items
// depends on ltsc_pkg for field widths
`default_nettype none

interface ltsc_in_if;
  logic                                valid;
  logic                                ready;
  logic [ltsc_pkg::TIME_W-1:0]         now_ms;
  logic [ltsc_pkg::CMD_W-1:0]          vision_cmd;
  logic                                track_valid;
  logic signed [ltsc_pkg::ERR_W-1:0]   track_error;

  modport source (output valid, now_ms, vision_cmd, track_valid, track_error, input ready);
  modport sink   (input valid, now_ms, vision_cmd, track_valid, track_error, output ready);
endinterface

interface ltsc_out_if;
  logic                                valid;
  logic                                ready;
  logic [ltsc_pkg::MOT_W-1:0]          motion;
  logic                                stand_pulse;
  logic                                params_update;
  logic signed [ltsc_pkg::STEER_W-1:0] steer_q8;
  logic                                boost_active;
  logic                                trot_tick;

  modport source (output valid, motion, stand_pulse, params_update, steer_q8, boost_active,
                  trot_tick, input ready);
  modport sink   (input valid, motion, stand_pulse, params_update, steer_q8, boost_active,
                  trot_tick, output ready);
endinterface

`default_nettype wire

/* sv/line_track_steer_controller_core.sv */
// line track steer controller top level: input register, control pass, result register
// depends on ltsc_pkg, ltsc_if and ltsc_steer
`default_nettype none

// One control pass per beat. A pass is captured in an input register, worked by
// combinational logic (a 17x16 multiply for the steer, then clamp and timer compares)
// and written with the state update into the result register, so the block takes a
// new pass every cycle while results are taken. The result register and the input
// register stall together when the result is not taken. Configuration writes through
// cfg_we/cfg_idx/cfg_data land on the next clock; write them only while no pass is in
// flight. There is no clearing pass after reset.
module line_track_steer_controller_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  ltsc_in_if.sink                                in_bus,
  ltsc_out_if.source                             out_bus,
  input  wire logic                              cfg_we,
  input  wire logic [ltsc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [ltsc_pkg::CFG_W-1:0]        cfg_data
);

  // configuration
  logic [ltsc_pkg::DB_W-1:0]  deadband_r;
  logic [ltsc_pkg::CFG_W-1:0] gain_r, max_r, recover_r, gait_r;

  // input register
  logic                              in_v_r;
  logic [ltsc_pkg::TIME_W-1:0]       now_r;
  logic [ltsc_pkg::CMD_W-1:0]        cmd_r;
  logic                              tvalid_r;
  logic signed [ltsc_pkg::ERR_W-1:0] err_r;

  // controller state
  logic [ltsc_pkg::MOT_W-1:0]  cur_r, cur_nxt;
  logic [ltsc_pkg::MOT_W-1:0]  recov_r, recov_nxt;
  logic [ltsc_pkg::TIME_W-1:0] lgait_r, lgait_nxt;
  logic [ltsc_pkg::TIME_W-1:0] ltrack_r, ltrack_nxt;
  logic                        seen_r, seen_nxt;
  logic                        boost_r, boost_nxt;

  // result register
  logic                               out_v_r;
  logic [ltsc_pkg::MOT_W-1:0]         o_motion_r;
  logic                               o_stand_r, o_upd_r, o_boost_r, o_tick_r;
  logic signed [ltsc_pkg::STEER_W-1:0] o_steer_r;

  logic                                stand_nxt, upd_nxt, tick_nxt;
  logic signed [ltsc_pkg::STEER_W-1:0] steer_nxt;
  logic [ltsc_pkg::TIME_W-1:0]         lost;
  logic                                is_cmd;
  logic                                advance;
  ltsc_pkg::steer_t                    steer;

  assign advance      = in_v_r && (!out_v_r || out_bus.ready);
  assign in_bus.ready = !in_v_r || advance;

  ltsc_steer u_steer (
    .track_error (err_r),
    .deadband    (deadband_r),
    .gain_q16    (gain_r),
    .max_q8      (max_r),
    .steer       (steer)
  );

  assign lost   = now_r - ltrack_r;
  assign is_cmd = (cmd_r == ltsc_pkg::CMD_PLATFORM) || (cmd_r == ltsc_pkg::CMD_STOP);

  always_comb begin
    cur_nxt    = cur_r;
    recov_nxt  = recov_r;
    lgait_nxt  = lgait_r;
    ltrack_nxt = ltrack_r;
    seen_nxt   = seen_r;
    boost_nxt  = boost_r;
    stand_nxt  = 1'b0;
    upd_nxt    = 1'b0;
    tick_nxt   = 1'b0;
    steer_nxt  = '0;

    if (is_cmd) begin
      seen_nxt   = 1'b0;
      ltrack_nxt = now_r;
      recov_nxt  = ltsc_pkg::MOT_FWD;
      stand_nxt  = (cur_nxt != ltsc_pkg::MOT_STOP);
      cur_nxt    = ltsc_pkg::MOT_STOP;
      if (cmd_r == ltsc_pkg::CMD_PLATFORM) begin
        boost_nxt = 1'b1;
      end
    end

    if (tvalid_r) begin
      seen_nxt   = 1'b1;
      ltrack_nxt = now_r;
      upd_nxt    = 1'b1;
      if (steer.turn_right) begin
        steer_nxt = {1'b0, steer.mag};
        recov_nxt = ltsc_pkg::MOT_RIGHT;
        cur_nxt   = ltsc_pkg::MOT_RIGHT;
      end else if (steer.turn_left) begin
        steer_nxt = ltsc_pkg::STEER_W'(0) - $signed({1'b0, steer.mag});
        recov_nxt = ltsc_pkg::MOT_LEFT;
        cur_nxt   = ltsc_pkg::MOT_LEFT;
      end else begin
        recov_nxt = ltsc_pkg::MOT_FWD;
        cur_nxt   = ltsc_pkg::MOT_FWD;
      end
    end else if (seen_nxt) begin
      // lost time is taken from the track time before this pass
      if (lost < {16'd0, recover_r}) begin
        cur_nxt = recov_nxt;
      end else begin
        stand_nxt = stand_nxt | (cur_nxt != ltsc_pkg::MOT_STOP);
        cur_nxt   = ltsc_pkg::MOT_STOP;
      end
    end

    if ((cur_nxt != ltsc_pkg::MOT_STOP) && ((now_r - lgait_r) >= {16'd0, gait_r})) begin
      lgait_nxt = now_r;
      tick_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= ltsc_pkg::RST_DEADBAND;
      gain_r     <= ltsc_pkg::RST_GAIN;
      max_r      <= ltsc_pkg::RST_MAX;
      recover_r  <= ltsc_pkg::RST_RECOVER;
      gait_r     <= ltsc_pkg::RST_GAIT;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ltsc_pkg::REG_DEADBAND: deadband_r <= cfg_data[ltsc_pkg::DB_W-1:0];
        ltsc_pkg::REG_GAIN:     gain_r     <= cfg_data;
        ltsc_pkg::REG_MAX:      max_r      <= cfg_data;
        ltsc_pkg::REG_RECOVER:  recover_r  <= cfg_data;
        ltsc_pkg::REG_GAIT:     gait_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_v_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      now_r    <= in_bus.now_ms;
      cmd_r    <= in_bus.vision_cmd;
      tvalid_r <= in_bus.track_valid;
      err_r    <= in_bus.track_error;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= ltsc_pkg::MOT_FWD;
      recov_r  <= ltsc_pkg::MOT_FWD;
      lgait_r  <= '0;
      ltrack_r <= '0;
      seen_r   <= 1'b0;
      boost_r  <= 1'b0;
    end else if (advance) begin
      cur_r    <= cur_nxt;
      recov_r  <= recov_nxt;
      lgait_r  <= lgait_nxt;
      ltrack_r <= ltrack_nxt;
      seen_r   <= seen_nxt;
      boost_r  <= boost_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_motion_r <= cur_nxt;
      o_stand_r  <= stand_nxt;
      o_upd_r    <= upd_nxt;
      o_steer_r  <= steer_nxt;
      o_boost_r  <= boost_nxt;
      o_tick_r   <= tick_nxt;
    end
  end

  assign out_bus.valid         = out_v_r;
  assign out_bus.motion        = o_motion_r;
  assign out_bus.stand_pulse   = o_stand_r;
  assign out_bus.params_update = o_upd_r;
  assign out_bus.steer_q8      = o_steer_r;
  assign out_bus.boost_active  = o_boost_r;
  assign out_bus.trot_tick     = o_tick_r;

endmodule

`default_nettype wire

/* sv/ltsc_steer.sv */
// steer unit: deadband test, |error| times q16 gain, clamp to max steer
// depends on ltsc_pkg
`default_nettype none

module ltsc_steer (
  input  wire logic signed [ltsc_pkg::ERR_W-1:0] track_error,
  input  wire logic [ltsc_pkg::DB_W-1:0]         deadband,
  input  wire logic [ltsc_pkg::CFG_W-1:0]        gain_q16,
  input  wire logic [ltsc_pkg::CFG_W-1:0]        max_q8,
  output ltsc_pkg::steer_t                       steer
);

  logic [ltsc_pkg::ERR_W:0]                     err_ext;
  logic [ltsc_pkg::ERR_W:0]                     abs_err;
  logic [ltsc_pkg::ERR_W+ltsc_pkg::CFG_W:0]     prod;
  logic [ltsc_pkg::ERR_W+ltsc_pkg::CFG_W-8:0]   scaled;
  logic                                         outside;

  assign err_ext = {track_error[ltsc_pkg::ERR_W-1], track_error};
  // 17 bits so that the most negative error has a magnitude
  assign abs_err = track_error[ltsc_pkg::ERR_W-1] ? ((ltsc_pkg::ERR_W+1)'(0) - err_ext)
                                                  : err_ext;
  assign prod    = {{ltsc_pkg::CFG_W{1'b0}}, abs_err} *
                   {{(ltsc_pkg::ERR_W+1){1'b0}}, gain_q16};
  assign scaled  = prod[ltsc_pkg::ERR_W+ltsc_pkg::CFG_W:8];
  assign outside = abs_err > {2'b00, deadband};

  always_comb begin
    steer.turn_right = outside && !track_error[ltsc_pkg::ERR_W-1];
    steer.turn_left  = outside && track_error[ltsc_pkg::ERR_W-1];
    if (scaled > {{(ltsc_pkg::ERR_W+1-8){1'b0}}, max_q8}) begin
      steer.mag = max_q8;
    end else begin
      steer.mag = scaled[ltsc_pkg::MAG_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* sv/ltsc_checker.sv */
// port-level checks for the line track steer controller, bound to the top level
// depends on ltsc_pkg and line_track_steer_controller_core
`default_nettype none

module ltsc_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [ltsc_pkg::MOT_W-1:0]         out_motion,
  input wire logic                               out_stand_pulse,
  input wire logic                               out_params_update,
  input wire logic signed [ltsc_pkg::STEER_W-1:0] out_steer_q8,
  input wire logic                               out_trot_tick
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_motion) && $stable(out_steer_q8))
    else $error("stalled result changed");

  // a measurement in the same pass may move the block again after the stop
  a_stand_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stand_pulse && !out_params_update |-> out_motion == ltsc_pkg::MOT_STOP)
    else $error("stand pulse without stop");

  a_steer_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_steer_q8 != '0) |->
      out_params_update &&
      ((out_steer_q8[ltsc_pkg::STEER_W-1] && out_motion == ltsc_pkg::MOT_LEFT) ||
       (!out_steer_q8[ltsc_pkg::STEER_W-1] && out_motion == ltsc_pkg::MOT_RIGHT)))
    else $error("steer sign disagrees with motion");

  a_tick_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trot_tick |-> out_motion != ltsc_pkg::MOT_STOP)
    else $error("trot tick while stopped");

endmodule

bind line_track_steer_controller_core ltsc_checker u_ltsc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .out_motion        (out_bus.motion),
  .out_stand_pulse   (out_bus.stand_pulse),
  .out_params_update (out_bus.params_update),
  .out_steer_q8      (out_bus.steer_q8),
  .out_trot_tick     (out_bus.trot_tick)
);

`default_nettype wire

/* tb/ltsc_pass_checker.sv */
// result checker for the line track steer controller: watches the pass, result and
// register write ports, predicts each result and compares it field by field
// depends on ltsc_pkg and ltsc_if
module ltsc_pass_checker
  import ltsc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  ltsc_in_if                        in_bus,
  ltsc_out_if                       out_bus,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output int                        mismatches,
  output int                        outstanding,
  output int                        results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [MOT_W-1:0]          motion;
    logic                      stand_pulse;
    logic                      params_update;
    logic signed [STEER_W-1:0] steer_q8;
    logic                      boost_active;
    logic                      trot_tick;
  } pass_result_t;

  pass_result_t pending_results[$];
  pass_result_t want;

  // register copies
  logic [DB_W-1:0]  band_lim;
  logic [CFG_W-1:0] gain_q16;
  logic [CFG_W-1:0] steer_cap;
  logic [CFG_W-1:0] hold_ms;
  logic [CFG_W-1:0] gait_ms;

  // controller state copies
  logic [MOT_W-1:0]  motion_now;
  logic [MOT_W-1:0]  motion_hold;
  logic [TIME_W-1:0] gait_mark;
  logic [TIME_W-1:0] track_mark;
  logic              track_seen;
  logic              boost_on;

  function automatic logic [MAG_W-1:0] steer_size(input logic [16:0] err_abs);
    logic [47:0] prod;
    prod = ({31'd0, err_abs} * {32'd0, gain_q16}) >> 8;
    if (prod > {32'd0, steer_cap}) return steer_cap;
    return prod[MAG_W-1:0];
  endfunction

  function automatic pass_result_t predict_pass(input logic [TIME_W-1:0] now,
                                                input logic [CMD_W-1:0] cmd,
                                                input logic trk,
                                                input logic signed [ERR_W-1:0] err);
    pass_result_t r;
    logic [TIME_W-1:0] since_track;
    logic [MAG_W-1:0] mag;
    int err_i;
    int band_i;
    int neg;
    r = '0;
    // loss time is taken before this pass moves the track stamp
    since_track = now - track_mark;
    err_i = int'(err);
    band_i = int'(band_lim);
    neg = -err_i;
    if (cmd == CMD_PLATFORM || cmd == CMD_STOP) begin
      track_seen = 1'b0;
      track_mark = now;
      motion_hold = MOT_FWD;
      if (motion_now != MOT_STOP) begin
        r.stand_pulse = 1'b1;
        motion_now = MOT_STOP;
      end
      if (cmd == CMD_PLATFORM) boost_on = 1'b1;
    end
    // a measurement overrides whatever the command did to the motion
    if (trk) begin
      track_seen = 1'b1;
      track_mark = now;
      r.params_update = 1'b1;
      if (err_i > band_i) begin
        mag = steer_size(err_i[16:0]);
        r.steer_q8 = {1'b0, mag};
        motion_hold = MOT_RIGHT;
        motion_now = MOT_RIGHT;
      end else if (err_i < -band_i) begin
        mag = steer_size(neg[16:0]);
        r.steer_q8 = 17'd0 - {1'b0, mag};
        motion_hold = MOT_LEFT;
        motion_now = MOT_LEFT;
      end else begin
        motion_hold = MOT_FWD;
        motion_now = MOT_FWD;
      end
    end else if (track_seen) begin
      if (since_track < {16'd0, hold_ms}) begin
        motion_now = motion_hold;
      end else if (motion_now != MOT_STOP) begin
        r.stand_pulse = 1'b1;
        motion_now = MOT_STOP;
      end
    end
    if (motion_now != MOT_STOP && (now - gait_mark) >= {16'd0, gait_ms}) begin
      gait_mark = now;
      r.trot_tick = 1'b1;
    end
    r.motion = motion_now;
    r.boost_active = boost_on;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("%0t ns: result %0d %s", $time, results_seen, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      band_lim = RST_DEADBAND;
      gain_q16 = RST_GAIN;
      steer_cap = RST_MAX;
      hold_ms = RST_RECOVER;
      gait_ms = RST_GAIT;
      motion_now = MOT_FWD;
      motion_hold = MOT_FWD;
      gait_mark = '0;
      track_mark = '0;
      track_seen = 1'b0;
      boost_on = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_DEADBAND: band_lim = cfg_data[DB_W-1:0];
          REG_GAIN:     gain_q16 = cfg_data;
          REG_MAX:      steer_cap = cfg_data;
          REG_RECOVER:  hold_ms = cfg_data;
          REG_GAIT:     gait_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready)
        pending_results.push_back(predict_pass(in_bus.now_ms, in_bus.vision_cmd,
                                               in_bus.track_valid, in_bus.track_error));
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("beat arrived with no pass outstanding");
        end else begin
          want = pending_results.pop_front();
          check_field("motion", 32'(out_bus.motion), 32'(want.motion));
          check_field("stand_pulse", 32'(out_bus.stand_pulse), 32'(want.stand_pulse));
          check_field("params_update", 32'(out_bus.params_update),
                      32'(want.params_update));
          check_field("steer_q8", 32'(out_bus.steer_q8), 32'(want.steer_q8));
          check_field("boost_active", 32'(out_bus.boost_active), 32'(want.boost_active));
          check_field("trot_tick", 32'(out_bus.trot_tick), 32'(want.trot_tick));
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

/* tb/tb.sv */
// top of the line track steer controller bench: clock, reset, pass stimulus across
// several register settings, result backpressure and the final verdict
// depends on ltsc_pkg, ltsc_if, the core and ltsc_pass_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ltsc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  logic                 steady = 1'b0;
  int                   mismatches;
  int                   outstanding;
  int                   results_seen;
  int                   passes_sent;
  int                   band_cfg;
  int                   hold_cfg;
  logic [TIME_W-1:0]    clock_ms;

  ltsc_in_if  in_bus();
  ltsc_out_if out_bus();

  line_track_steer_controller_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  ltsc_pass_checker pass_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_bus       (in_bus),
    .out_bus      (out_bus),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side stalls now and then, never in the steady stretch
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= steady || ($urandom_range(99) >= 8);
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_pass(input logic [TIME_W-1:0] t, input logic [CMD_W-1:0] cmd,
                           input logic trk, input logic signed [ERR_W-1:0] err);
    if (!steady && $urandom_range(99) < 8) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.now_ms      <= t;
    in_bus.vision_cmd  <= cmd;
    in_bus.track_valid <= trk;
    in_bus.track_error <= err;
    do @(posedge clk); while (!in_bus.ready);
    passes_sent++;
  endtask

  // hold off until every pass has its result, then let the pipe empty
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [DB_W-1:0] band, input logic [CFG_W-1:0] gain,
                               input logic [CFG_W-1:0] cap, input logic [CFG_W-1:0] hold,
                               input logic [CFG_W-1:0] gait);
    write_reg(REG_DEADBAND, {1'b0, band});
    write_reg(REG_GAIN, gain);
    write_reg(REG_MAX, cap);
    write_reg(REG_RECOVER, hold);
    write_reg(REG_GAIT, gait);
    cfg_we <= 1'b0;
    band_cfg = int'(band);
    hold_cfg = int'(hold);
  endtask

  // mostly a plausible pass stream: rising time, runs of track loss, rare commands;
  // the rest is noise with arbitrary fields
  task automatic run_random(input int count);
    int pick;
    int loss_run;
    int step_max;
    int e;
    logic [TIME_W-1:0]       t;
    logic [CMD_W-1:0]        cmd;
    logic                    trk;
    logic signed [ERR_W-1:0] err;
    loss_run = 0;
    clock_ms = $urandom;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) settle();
      pick = $urandom_range(99);
      if (pick < 8) begin
        t = $urandom;
        cmd = CMD_W'($urandom_range(3));
        trk = 1'($urandom_range(1));
        err = ERR_W'($urandom);
      end else begin
        if (loss_run == 0 && $urandom_range(9) == 0) loss_run = $urandom_range(1, 12);
        step_max = (loss_run > 0) ? hold_cfg / 3 + 20 : 60;
        clock_ms += $urandom_range(step_max);
        t = clock_ms;
        pick = $urandom_range(99);
        cmd = (pick < 5) ? CMD_PLATFORM : (pick < 10) ? CMD_STOP :
              (pick < 12) ? CMD_UNUSED : CMD_NONE;
        trk = (loss_run == 0);
        if (loss_run > 0) loss_run--;
        case ($urandom_range(2))
          0: begin
            // right around the deadband edge
            e = band_cfg + int'($urandom_range(2)) - 1;
            if ($urandom_range(1)) e = -e;
          end
          1: e = int'($urandom_range(4 * band_cfg + 128)) - (2 * band_cfg + 64);
          default: e = $signed(16'($urandom));
        endcase
        if (e > 32767) e = 32767;
        if (e < -32768) e = -32768;
        err = e[15:0];
      end
      send_pass(t, cmd, trk, err);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_DEADBAND;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.now_ms = '0;
    in_bus.vision_cmd = CMD_NONE;
    in_bus.track_valid = 1'b0;
    in_bus.track_error = '0;
    passes_sent = 0;
    band_cfg = int'(RST_DEADBAND);
    hold_cfg = int'(RST_RECOVER);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed passes on the reset settings
    send_pass(32'd0, CMD_NONE, 1'b0, 16'sd0);
    send_pass(32'd200, CMD_NONE, 1'b1, 16'sd35);
    send_pass(32'd210, CMD_NONE, 1'b1, 16'sd36);
    send_pass(32'd220, CMD_NONE, 1'b1, -16'sd36);
    send_pass(32'd230, CMD_NONE, 1'b1, -16'sd35);
    send_pass(32'd240, CMD_NONE, 1'b1, 16'sh7FFF);
    send_pass(32'd250, CMD_NONE, 1'b1, 16'sh8000);
    send_pass(32'd300, CMD_NONE, 1'b0, 16'sd12345);
    send_pass(32'd749, CMD_NONE, 1'b0, 16'sd0);
    send_pass(32'd750, CMD_NONE, 1'b0, 16'sd0);
    send_pass(32'd800, CMD_NONE, 1'b0, 16'sd0);
    send_pass(32'd810, CMD_STOP, 1'b0, 16'sd0);
    send_pass(32'd820, CMD_UNUSED, 1'b0, 16'sd0);
    send_pass(32'd830, CMD_NONE, 1'b1, 16'sd100);
    send_pass(32'd840, CMD_PLATFORM, 1'b0, 16'sd0);
    send_pass(32'd850, CMD_STOP, 1'b1, -16'sd500);
    send_pass(32'd860, CMD_PLATFORM, 1'b1, 16'sd0);
    send_pass(32'hFFFF_FFF0, CMD_NONE, 1'b0, 16'sd0);
    send_pass(32'hFFFF_FFFF, CMD_NONE, 1'b1, 16'sd1000);
    send_pass(32'd5, CMD_NONE, 1'b0, 16'sd0);
    send_pass(32'd600, CMD_NONE, 1'b0, 16'sd0);
    // loss long enough to wrap back into the recovery window
    send_pass(32'd9, CMD_NONE, 1'b0, 16'sd0);
    send_pass(32'd20, CMD_UNUSED, 1'b1, -16'sd40);

    run_random(100);
    settle();

    load_settings(15'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    steady = 1'b1;
    run_random(100);
    steady = 1'b0;
    settle();

    load_settings(15'h7FFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    run_random(100);
    settle();

    repeat (3) begin
      load_settings(DB_W'($urandom_range(400)), CFG_W'($urandom), CFG_W'($urandom),
                    CFG_W'($urandom_range(800)), CFG_W'($urandom_range(300)));
      run_random(100);
      settle();
    end

    load_settings(RST_DEADBAND, RST_GAIN, RST_MAX, RST_RECOVER, RST_GAIT);
    run_random(100);

    in_bus.valid <= 1'b0;
    for (int w = 0; w < 2000 && outstanding != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d passes and %0d results over 7 register settings",
             passes_sent, results_seen);
    $display("incl. deadband edges, steer clamps, command overrides, loss recovery, time wrap");
    if (outstanding != 0) $display("%0d expected results never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* line_track_steer_controller_core.f */
sv/ltsc_pkg.sv
sv/ltsc_if.sv
sv/ltsc_steer.sv
sv/line_track_steer_controller_core.sv
sv/ltsc_checker.sv
tb/ltsc_pass_checker.sv
tb/tb.sv
